// ===== rtl/nhaq_pkg.sv =====
package nhaq_pkg;

  // Configuration register indices
  typedef enum logic [1:0] {
    CFG_ALARM_THRESHOLD  = 2'd0,
    CFG_FAULT_HIGH_BOUND = 2'd1,
    CFG_FAULT_LOW_BOUND  = 2'd2
  } cfg_index_t;

  // Register values after reset
  localparam logic [6:0] ALARM_THRESHOLD_RST  = 7'd60;
  localparam logic [7:0] FAULT_HIGH_BOUND_RST = 8'd250;
  localparam logic [7:0] FAULT_LOW_BOUND_RST  = 8'd5;

  // Defined entries of the falling thermistor curve; later entries read as zero
  localparam int NTC_TABLE_DEPTH = 84;

  localparam logic [7:0] NTC_TABLE [NTC_TABLE_DEPTH] = '{
    8'd222, 8'd221, 8'd219, 8'd218, 8'd216, 8'd215, 8'd213, 8'd211, 8'd209, 8'd207,
    8'd206, 8'd204, 8'd202, 8'd200, 8'd198, 8'd195, 8'd193, 8'd191, 8'd189, 8'd187,
    8'd184, 8'd182, 8'd180, 8'd177, 8'd175, 8'd172, 8'd170, 8'd167, 8'd165, 8'd162,
    8'd160, 8'd157, 8'd155, 8'd152, 8'd149, 8'd147, 8'd144, 8'd142, 8'd139, 8'd137,
    8'd134, 8'd131, 8'd129, 8'd126, 8'd124, 8'd121, 8'd119, 8'd116, 8'd114, 8'd111,
    8'd109, 8'd107, 8'd104, 8'd102, 8'd100, 8'd97,  8'd95,  8'd93,  8'd91,  8'd89,
    8'd87,  8'd85,  8'd83,  8'd81,  8'd79,  8'd77,  8'd75,  8'd73,  8'd71,  8'd69,
    8'd68,  8'd66,  8'd64,  8'd63,  8'd61,  8'd60,  8'd58,  8'd57,  8'd55,  8'd54,
    8'd52,  8'd51,  8'd50,  8'd49
  };

  function automatic logic [7:0] table_entry(input logic [7:0] idx);
    logic [7:0] val;
    val = 8'd0;
    if (idx < 8'(NTC_TABLE_DEPTH)) begin
      val = NTC_TABLE[idx[6:0]];
    end
    return val;
  endfunction

  typedef struct packed {
    logic [7:0] adc_sample;
  } in_payload_t;

  typedef struct packed {
    logic [6:0] temperature;
    logic       fire_detect;
    logic       clear_detect;
    logic       sample_fault;
    logic       sensor_error;
  } out_payload_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [7:0] wdata;
  } cfg_payload_t;

  // Live configuration handed to the qualifier
  typedef struct packed {
    logic [6:0] alarm_threshold;
    logic [7:0] fault_high_bound;
    logic [7:0] fault_low_bound;
  } cfg_t;

endpackage

// ===== rtl/nhaq_chan_if.sv =====
interface nhaq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/nhaq_temp_lookup.sv =====
module nhaq_temp_lookup #(
  parameter int TABLE_ENTRIES = 84,
  parameter int IDX_W = 7
) (
  input  logic [7:0]       sample,
  output logic [IDX_W-1:0] temp_idx
);

  // Priority search: the first entry the sample reaches wins, else clamp to the last
  always_comb begin
    temp_idx = IDX_W'(TABLE_ENTRIES - 1);
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (sample >= nhaq_pkg::table_entry(8'(i))) begin
        temp_idx = IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/nhaq_qualifier.sv =====
module nhaq_qualifier #(
  parameter int IDX_W = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            sample,
  input  logic [IDX_W-1:0]      temp_idx,
  input  nhaq_pkg::cfg_t        cfg,
  output nhaq_pkg::out_payload_t result
);

  logic [6:0] fault_hist_r;
  logic [1:0] over_hist_r;
  logic       error_r;

  logic       fault;
  logic       over;
  logic [7:0] fault_win;
  logic [2:0] over_win;
  logic       error_nxt;

  // Fault and over-temperature tests for the current sample
  always_comb begin
    fault     = (sample >= cfg.fault_high_bound) || (sample <= cfg.fault_low_bound);
    over      = 8'(temp_idx) > {1'b0, cfg.alarm_threshold};
    fault_win = {fault_hist_r, fault};
    over_win  = {over_hist_r, over};
    error_nxt = error_r | (&fault_win);
  end

  always_comb begin
    result.temperature  = 7'(temp_idx);
    result.fire_detect  = &over_win;
    result.clear_detect = ~|over_win;
    result.sample_fault = fault;
    result.sensor_error = error_nxt;
  end

  // Shift histories and latch the error when a sample moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_hist_r <= '0;
      over_hist_r  <= '0;
      error_r      <= 1'b0;
    end else if (advance) begin
      fault_hist_r <= fault_win[6:0];
      over_hist_r  <= over_win[1:0];
      error_r      <= error_nxt;
    end
  end

endmodule

// ===== rtl/ntc_heat_alarm_qualifier_unit.sv =====
// NTC heat alarm qualifier.
// in_ch carries one averaged 8-bit converter sample per transaction; out_ch
// returns one result per sample: table temperature (0..TABLE_ENTRIES-1,
// clamped), fire and clear detects over the last three samples, the sample
// fault flag and the sticky sensor-error flag. cfg_ch writes the alarm
// threshold and the two fault bounds; it is always ready and should only be
// used while no sample is in flight.
// A sample accepted on in_ch passes through the input register and then the
// result register before it is offered on out_ch.
// Throughput: one sample per cycle while out_ch does not stall; the table
// search is a parallel compare and priority encode between the two registers.
// When out_ch stalls the result register holds and one more sample may be
// taken into the input register; in_ch ready then drops until out_ch moves.
// Reset clears the histories and the error flag and loads the register
// defaults (threshold 60, high bound 250, low bound 5).
module ntc_heat_alarm_qualifier_unit #(
  parameter int TABLE_ENTRIES = 84
) (
  input logic clk,
  input logic rst_n,
  nhaq_chan_if.sink   in_ch,
  nhaq_chan_if.source out_ch,
  nhaq_chan_if.sink   cfg_ch
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  nhaq_pkg::cfg_t         cfg_r;
  logic                   s1_v_r;
  logic [7:0]             s1_sample_r;
  logic                   out_v_r;
  nhaq_pkg::out_payload_t out_r;

  logic                   out_free;
  logic                   s1_adv;
  logic [IDX_W-1:0]       temp_idx;
  nhaq_pkg::out_payload_t result;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_threshold  <= nhaq_pkg::ALARM_THRESHOLD_RST;
      cfg_r.fault_high_bound <= nhaq_pkg::FAULT_HIGH_BOUND_RST;
      cfg_r.fault_low_bound  <= nhaq_pkg::FAULT_LOW_BOUND_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.payload.reg_index)
        nhaq_pkg::CFG_ALARM_THRESHOLD:  cfg_r.alarm_threshold  <= cfg_ch.payload.wdata[6:0];
        nhaq_pkg::CFG_FAULT_HIGH_BOUND: cfg_r.fault_high_bound <= cfg_ch.payload.wdata;
        nhaq_pkg::CFG_FAULT_LOW_BOUND:  cfg_r.fault_low_bound  <= cfg_ch.payload.wdata;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_adv      = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_r <= in_ch.payload.adc_sample;
    end
  end

  nhaq_temp_lookup #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_lookup (
    .sample  (s1_sample_r),
    .temp_idx(temp_idx)
  );

  nhaq_qualifier #(
    .IDX_W(IDX_W)
  ) u_qualifier (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .sample  (s1_sample_r),
    .temp_idx(temp_idx),
    .cfg     (cfg_r),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= result;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.payload = out_r;

`ifndef SYNTHESIS
  // Sensor error never falls back once shown
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.sensor_error) |=>
      (!out_ch.valid || out_ch.payload.sensor_error))
    else $error("sensor error flag cleared after being set");

  // A sample leaving the input register is offered next cycle
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_ch.valid)
    else $error("advanced sample not offered on result channel");

  // Input only blocks when both registers are full and the result stalls
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && out_v_r && !out_ch.ready))
    else $error("input blocked without a full pipeline");
`endif

endmodule
